// ===== rtl/pbfs_pkg.sv =====
package pbfs_pkg;

    // Field widths fixed by the item format
    localparam int MAP_W   = 64;
    localparam int LEN_W   = 7;
    localparam int PAGE_W  = 6;

    // Default page count
    localparam int PAGE_COUNT_DEF = 64;

    // Search policy codes
    localparam logic POLICY_FIRST = 1'b0;
    localparam logic POLICY_WORST = 1'b1;

    // Request item
    typedef struct packed {
        logic [MAP_W-1:0] page_map;
        logic [LEN_W-1:0] run_length_needed;
    } t_req;

    // Result item
    typedef struct packed {
        logic              found;
        logic [PAGE_W-1:0] start_page;
    } t_res;

    // Scan state carried from cell to cell with each item
    typedef struct packed {
        logic [MAP_W-1:0]  page_map;
        logic [LEN_W-1:0]  k;          // wanted length, zero already taken as one
        logic              worst;      // policy latched at accept
        logic              done;       // first fit already resolved
        logic              hit;
        logic [PAGE_W-1:0] pick;
        logic [PAGE_W-1:0] run_start;
        logic [LEN_W-1:0]  run_len;
        logic [LEN_W-1:0]  best_len;
    } t_scan;

endpackage

// ===== rtl/pbfs_cell.sv =====
module pbfs_cell #(
    parameter int PAGE_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pbfs_pkg::t_scan i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output pbfs_pkg::t_scan o_data
);
    import pbfs_pkg::*;

    logic  r_valid;
    t_scan r_data;
    t_scan n_data;
    logic  free_page;
    logic  [LEN_W-1:0] grow_len;
    logic  [PAGE_W-1:0] grow_start;

    // Hold while the neighbor downstream is blocked and this slot is full
    assign o_stall = r_valid && i_stall;

    assign free_page  = !i_data.page_map[PAGE_IDX];
    assign grow_len   = i_data.run_len + LEN_W'(1);
    assign grow_start = (i_data.run_len == '0) ? PAGE_W'(PAGE_IDX) : i_data.run_start;

    // One page of the scan
    always_comb begin
        n_data = i_data;
        if (!i_data.done) begin
            if (free_page) begin
                n_data.run_start = grow_start;
                n_data.run_len   = grow_len;
                if (i_data.worst == POLICY_FIRST && grow_len >= i_data.k) begin
                    n_data.hit  = 1'b1;
                    n_data.pick = grow_start;
                    n_data.done = 1'b1;
                end
            end else begin
                // Used page closes the current run
                if (i_data.worst == POLICY_WORST && i_data.run_len >= i_data.k &&
                    i_data.run_len > i_data.best_len) begin
                    n_data.best_len = i_data.run_len;
                    n_data.pick     = i_data.run_start;
                    n_data.hit      = 1'b1;
                end
                n_data.run_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // A resolved first fit passes through untouched
    a_done_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.done) |=>
        (r_data.done && r_data.pick == $past(i_data.pick)))
        else $error("resolved item changed in cell");

    // Done implies a hit
    a_done_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.done) |-> r_data.hit)
        else $error("done without hit");

    // A run cannot be longer than the pages seen so far
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.run_len <= LEN_W'(PAGE_IDX + 1)))
        else $error("run length beyond scanned pages");

endmodule

// ===== rtl/pbfs_out.sv =====
module pbfs_out #(
    parameter int PAGE_COUNT = pbfs_pkg::PAGE_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  pbfs_pkg::t_scan i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output pbfs_pkg::t_res  o_item
);
    import pbfs_pkg::*;

    logic  r_valid;
    t_res  r_item;
    t_res  n_item;
    logic  close_hit;
    logic  [PAGE_W-1:0] close_pick;
    logic  len_ok;

    assign o_stall = r_valid && i_stall;

    // End of map acts as a used page: close the last run for worst fit
    always_comb begin
        close_hit  = i_data.hit;
        close_pick = i_data.pick;
        if (!i_data.done && i_data.worst == POLICY_WORST &&
            i_data.run_len >= i_data.k && i_data.run_len > i_data.best_len) begin
            close_hit  = 1'b1;
            close_pick = i_data.run_start;
        end
    end

    // Lengths above the page count never fit
    assign len_ok = (i_data.k <= LEN_W'(PAGE_COUNT));

    always_comb begin
        n_item.found      = close_hit && len_ok;
        n_item.start_page = (close_hit && len_ok) ? close_pick : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.k > LEN_W'(PAGE_COUNT)) |=> !r_item.found)
        else $error("oversized length reported as found");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_data.hit && i_data.worst == POLICY_FIRST) |=>
        (!r_item.found && r_item.start_page == '0))
        else $error("first fit miss not reported as zero");

    a_first_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.done && len_ok) |=>
        (r_item.found && r_item.start_page == $past(i_data.pick)))
        else $error("first fit hit lost");

endmodule

// ===== rtl/page_bitmap_fit_search.sv =====
// Free-run search over a page occupancy bitmap, first fit or worst fit.
// Each item passes through one cell per page and then the result register.
// Throughput: one item per cycle unless the output stalls; the chain of page cells is fully pipelined.
// Reset (synchronous, active low) empties the chain and sets first fit.
module page_bitmap_fit_search #(
    parameter int PAGE_COUNT = pbfs_pkg::PAGE_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pbfs_pkg::t_req i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pbfs_pkg::t_res o_out_item,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_data
);
    import pbfs_pkg::*;

    logic  r_policy;
    t_scan head;
    t_scan s_data  [PAGE_COUNT+1];
    logic  s_valid [PAGE_COUNT+1];
    logic  s_stall [PAGE_COUNT+1];

    // Policy register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_FIRST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= i_cfg_data;
        end
    end

    // Scan state entering the first cell
    always_comb begin
        head           = '0;
        head.page_map  = i_in_item.page_map;
        head.k         = (i_in_item.run_length_needed == '0) ? LEN_W'(1)
                                                              : i_in_item.run_length_needed;
        head.worst     = r_policy;
    end

    assign s_data[0]  = head;
    assign s_valid[0] = i_in_valid;
    assign o_in_stall = s_stall[0];

    // One cell per page
    for (genvar g = 0; g < PAGE_COUNT; g++) begin : g_cell
        pbfs_cell #(
            .PAGE_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_stall (s_stall[g]),
            .i_data  (s_data[g]),
            .o_valid (s_valid[g+1]),
            .i_stall (s_stall[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    pbfs_out #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[PAGE_COUNT]),
        .o_stall (s_stall[PAGE_COUNT]),
        .i_data  (s_data[PAGE_COUNT]),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule
